[hdl/psm_pkg.sv]
// Shared types, codes and reset constants for the power state manager.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package psm_pkg;

  // register file indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_GOOD_MV       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOW_MV        = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_CRITICAL_MV   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IDLE_TIMEOUT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEEP_DELAY    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BURST_MAX     = 3'd5;

  localparam int unsigned CfgDataW = 32;

  // register reset values
  localparam logic [15:0] GOOD_MV_RST          = 16'd3700;
  localparam logic [15:0] LOW_MV_RST           = 16'd3400;
  localparam logic [15:0] CRITICAL_MV_RST      = 16'd3200;
  localparam logic [31:0] IDLE_TIMEOUT_RST     = 32'd30000;
  localparam logic [31:0] DEEP_DELAY_RST       = 32'd300000;
  localparam logic [31:0] BURST_MAX_RST        = 32'd5000;

  localparam logic [6:0]  PCT_FULL             = 7'd100;

  // percentage divider: quotient is below 128, so seven restoring steps
  localparam int unsigned QuotW = 7;
  localparam int unsigned NumW  = 23;   // (16-bit difference) * 100

  typedef enum logic [1:0] {
    KIND_UPDATE   = 2'd0,
    KIND_ACTIVITY = 2'd1,
    KIND_BURST    = 2'd2,
    KIND_INIT     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_ACTIVE   = 3'd0,
    MODE_IDLE     = 3'd1,
    MODE_DEEP     = 3'd2,
    MODE_CHARGING = 3'd3,
    MODE_FAULT    = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_SLEEP = 2'd1,
    CMD_WAKE  = 2'd2
  } pwr_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [15:0] sample_mv;
    logic        sample_charging;
    logic        sample_present;
    logic [31:0] burst_len_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] level_mv;
    logic [6:0]  level_pct;
    logic        is_charging;
    logic        burst_granted;
    logic [1:0]  radio_cmd;
    logic [1:0]  display_cmd;
  } out_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       load;       // capture the input item
    logic       mul;        // form (mv - critical) * 100
    logic       div_step;   // one restoring divide step
    logic [2:0] step;       // shift of the current divide step
    logic       commit;     // update state, load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    pwr_cmd_t radio;
    pwr_cmd_t display;
  } cmd_pair_t;

  // commands issued when a mode is entered
  function automatic cmd_pair_t entry_cmds(input mode_t m);
    cmd_pair_t c;
    case (m)
      MODE_ACTIVE:   c = '{radio: CMD_WAKE,  display: CMD_WAKE};
      MODE_IDLE:     c = '{radio: CMD_SLEEP, display: CMD_NONE};
      MODE_DEEP:     c = '{radio: CMD_SLEEP, display: CMD_SLEEP};
      MODE_CHARGING: c = '{radio: CMD_SLEEP, display: CMD_NONE};
      default:       c = '{radio: CMD_SLEEP, display: CMD_SLEEP};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/power_state_manager_unit.sv]
// Power state manager top level: ties the sequencer to the datapath.
// Depends on psm_pkg, psm_ctrl and psm_dp.
//
// Power mode controller with five modes (active, idle, deep sleep, charging,
// fault). Each item carries a millisecond timestamp and one of four kinds:
// battery update, activity mark, radio burst request or init; every item
// yields exactly one result item. Until its result is loaded, an item is
// captured, (mv - critical_mv) * 100 is formed, seven steps of the restoring
// divider yield the battery percentage (one quotient bit per cycle), and then
// the mode is decided and state updated. The block takes one item at a time
// and accepts no new item until the result of the last one is loaded.
// The result sits in an output register, so the next item is accepted while
// a result still waits; only a second finished result stalls the block.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered and
// must only happen while no item is in flight. Radio and display commands
// are nonzero only if the mode differs from the prior one (for init, active).
`default_nettype none

module power_state_manager_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [psm_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [psm_pkg::CfgDataW-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire psm_pkg::in_t                 in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output psm_pkg::out_t                     out_data
);

  psm_pkg::ctrl_cmd_t cmd;

  // sequencer: handshake and step count
  psm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: registers, divider, mode decision
  psm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[hdl/psm_ctrl.sv]
// Sequencer of the power state manager: handshake, divide step count, output valid.
// Depends on psm_pkg; drives psm_dp through a ctrl_cmd_t command struct.
`default_nettype none

module psm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output psm_pkg::ctrl_cmd_t      cmd
);

  psm_pkg::state_t state_r, state_nxt;
  logic [2:0]      step_r, step_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psm_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    cmd.step     = step_r;
    in_stall     = 1'b1;
    case (state_r)
      psm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = psm_pkg::ST_MUL;
        end
      end
      psm_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = 3'(psm_pkg::QuotW - 1);
        state_nxt = psm_pkg::ST_DIV;
      end
      psm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = psm_pkg::ST_DONE;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      psm_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = psm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psm_pkg::ST_IDLE;
    endcase
    out_valid_nxt = cmd.commit | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == psm_pkg::ST_MUL)
    else $error("accepted item did not start the multiply");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && step_r == '0) |=> state_r == psm_pkg::ST_DONE)
    else $error("last divide step did not finish the item");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mul, cmd.div_step, cmd.commit}))
    else $error("more than one datapath command at once");

endmodule

`default_nettype wire

[hdl/psm_dp.sv]
// Datapath of the power state manager: config registers, item capture,
// percentage divider, mode decision, state and output register. Depends on psm_pkg.
`default_nettype none

module psm_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [psm_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [psm_pkg::CfgDataW-1:0]    cfg_data,
  input  wire psm_pkg::in_t                    in_data,
  input  wire psm_pkg::ctrl_cmd_t              cmd,
  output psm_pkg::out_t                        out_data
);

  // configuration
  logic [15:0] good_r, low_r, crit_r;
  logic [31:0] idle_to_r, deep_dly_r, burst_max_r;

  // block state
  psm_pkg::mode_t mode_r, mode_nxt;
  logic [15:0]    mv_r, mv_nxt;
  logic [6:0]     pct_r, pct_nxt;
  logic           chg_r, chg_nxt;
  logic [31:0]    last_act_r, last_act_nxt;
  logic           pend_r, pend_nxt;
  logic [31:0]    end_r, end_nxt;

  // work registers
  psm_pkg::in_t                 item_r;
  logic [psm_pkg::NumW-1:0]     rem_r;
  logic [psm_pkg::QuotW-1:0]    quot_r;
  psm_pkg::out_t                out_r, out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_r      <= psm_pkg::GOOD_MV_RST;
      low_r       <= psm_pkg::LOW_MV_RST;
      crit_r      <= psm_pkg::CRITICAL_MV_RST;
      idle_to_r   <= psm_pkg::IDLE_TIMEOUT_RST;
      deep_dly_r  <= psm_pkg::DEEP_DELAY_RST;
      burst_max_r <= psm_pkg::BURST_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        psm_pkg::REG_GOOD_MV:      good_r      <= cfg_data[15:0];
        psm_pkg::REG_LOW_MV:       low_r       <= cfg_data[15:0];
        psm_pkg::REG_CRITICAL_MV:  crit_r      <= cfg_data[15:0];
        psm_pkg::REG_IDLE_TIMEOUT: idle_to_r   <= cfg_data;
        psm_pkg::REG_DEEP_DELAY:   deep_dly_r  <= cfg_data;
        psm_pkg::REG_BURST_MAX:    burst_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // percentage divider
  logic [15:0]              diff;
  logic [psm_pkg::NumW-1:0] prod;
  logic [psm_pkg::NumW-1:0] trial;
  logic                     fits;

  always_comb begin
    diff  = item_r.sample_mv - crit_r;
    // diff * 100 = diff * 64 + diff * 32 + diff * 4
    prod  = ({7'd0, diff} << 6) + ({7'd0, diff} << 5) + ({7'd0, diff} << 2);
    trial = {7'd0, good_r - crit_r} << cmd.step;
    fits  = rem_r >= trial;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.mul) begin
      rem_r  <= prod;
      quot_r <= '0;
    end else if (cmd.div_step) begin
      if (fits) begin
        rem_r <= rem_r - trial;
      end
      quot_r <= {quot_r[psm_pkg::QuotW-2:0], fits};
    end
  end

  // mode decision
  psm_pkg::kind_t    kind;
  psm_pkg::mode_t    base_mode;
  psm_pkg::mode_t    target;
  logic              base_pend;
  logic [31:0]       base_last;
  logic [31:0]       idle_for;
  logic [31:0]       len_clamp;
  logic              granted;
  logic              reach_timeouts;
  psm_pkg::cmd_pair_t cmds;

  always_comb begin
    kind      = psm_pkg::kind_t'(item_r.kind);
    // init starts from a cleared state
    base_mode = (kind == psm_pkg::KIND_INIT) ? psm_pkg::MODE_ACTIVE : mode_r;
    base_pend = (kind == psm_pkg::KIND_INIT) ? 1'b0 : pend_r;
    base_last = (kind == psm_pkg::KIND_INIT) ? item_r.now_ms : last_act_r;
    idle_for  = item_r.now_ms - base_last;
    len_clamp = (item_r.burst_len_ms > burst_max_r) ? burst_max_r : item_r.burst_len_ms;
    granted   = (kind == psm_pkg::KIND_BURST) && (mv_r > crit_r);
    reach_timeouts = 1'b0;
    target    = base_mode;

    mv_nxt       = mv_r;
    pct_nxt      = pct_r;
    chg_nxt      = chg_r;
    last_act_nxt = last_act_r;
    pend_nxt     = base_pend;
    end_nxt      = end_r;

    case (kind)
      psm_pkg::KIND_UPDATE, psm_pkg::KIND_INIT: begin
        mv_nxt  = item_r.sample_mv;
        chg_nxt = item_r.sample_charging;
        if (item_r.sample_mv <= crit_r) begin
          pct_nxt = '0;
        end else if (item_r.sample_mv >= good_r) begin
          pct_nxt = psm_pkg::PCT_FULL;
        end else begin
          pct_nxt = quot_r;
        end
        if (kind == psm_pkg::KIND_INIT) begin
          last_act_nxt = item_r.now_ms;
          end_nxt      = item_r.now_ms;
        end
        if (!item_r.sample_present) begin
          target = psm_pkg::MODE_FAULT;
        end else if (item_r.sample_mv <= crit_r) begin
          target = psm_pkg::MODE_DEEP;
        end else if (item_r.sample_charging) begin
          target = psm_pkg::MODE_CHARGING;
        end else if (base_pend && (item_r.now_ms < end_nxt)) begin
          target = psm_pkg::MODE_ACTIVE;
        end else begin
          reach_timeouts = 1'b1;
          if (idle_for < idle_to_r) begin
            target = psm_pkg::MODE_ACTIVE;
          end else if ((idle_for < deep_dly_r) && (item_r.sample_mv > low_r)) begin
            target = psm_pkg::MODE_IDLE;
          end else begin
            target = psm_pkg::MODE_DEEP;
          end
        end
        if (reach_timeouts) begin
          pend_nxt = 1'b0;
        end
      end
      psm_pkg::KIND_ACTIVITY: begin
        last_act_nxt = item_r.now_ms;
        if ((mode_r == psm_pkg::MODE_IDLE) || (mode_r == psm_pkg::MODE_DEEP)) begin
          target = psm_pkg::MODE_ACTIVE;
        end
      end
      psm_pkg::KIND_BURST: begin
        if (granted) begin
          pend_nxt = 1'b1;
          end_nxt  = item_r.now_ms + len_clamp;
          target   = psm_pkg::MODE_ACTIVE;
        end
      end
      default: ;
    endcase

    mode_nxt = target;
    cmds     = psm_pkg::entry_cmds(target);
    if (target == base_mode) begin
      cmds = '{radio: psm_pkg::CMD_NONE, display: psm_pkg::CMD_NONE};
    end

    out_nxt.mode          = target;
    out_nxt.level_mv      = mv_nxt;
    out_nxt.level_pct     = pct_nxt;
    out_nxt.is_charging   = chg_nxt;
    out_nxt.burst_granted = granted;
    out_nxt.radio_cmd     = cmds.radio;
    out_nxt.display_cmd   = cmds.display;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= psm_pkg::MODE_ACTIVE;
      mv_r       <= '0;
      pct_r      <= '0;
      chg_r      <= 1'b0;
      last_act_r <= '0;
      pend_r     <= 1'b0;
      end_r      <= '0;
    end else if (cmd.commit) begin
      mode_r     <= mode_nxt;
      mv_r       <= mv_nxt;
      pct_r      <= pct_nxt;
      chg_r      <= chg_nxt;
      last_act_r <= last_act_nxt;
      pend_r     <= pend_nxt;
      end_r      <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

  a_grant_active: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && granted) |=> mode_r == psm_pkg::MODE_ACTIVE)
    else $error("granted burst did not leave the block active");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    pct_r <= psm_pkg::PCT_FULL)
    else $error("stored percentage above full");

  a_cmd_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && target == base_mode) |=>
      (out_r.radio_cmd == psm_pkg::CMD_NONE && out_r.display_cmd == psm_pkg::CMD_NONE))
    else $error("wake or sleep command without a mode change");

endmodule

`default_nettype wire
